[hdl/btpc_pkg.sv]
// ----------------------------------------------------------------------------
// btpc_pkg: shared types and constants of the barometer compensation block
// Register indexes, pipeline depths and helper arithmetic functions.
// ----------------------------------------------------------------------------
`default_nettype none
package btpc_pkg;

    localparam int unsigned DivStages = 32;

    typedef enum logic [2:0] {
        REG_AC1    = 3'd0,
        REG_AC2    = 3'd1,
        REG_AC3    = 3'd2,
        REG_AC4    = 3'd3,
        REG_AC5    = 3'd4,
        REG_AC6    = 3'd5,
        REG_B1_B2  = 3'd6,
        REG_MC_MD  = 3'd7
    } reg_idx_t;

    localparam logic [31:0] B6_OFFSET = 32'd4000;
    localparam logic [31:0] B7_SCALE  = 32'd50000;
    localparam logic [31:0] X3_BIAS   = 32'd32768;
    localparam logic [31:0] P_SQ_K    = 32'd3038;
    localparam logic [31:0] P_LIN_K   = 32'd7357;
    localparam logic [31:0] P_OFS_K   = 32'd3791;

    // Sign-extend a 16-bit word to 32 bits
    function automatic logic [31:0] sx16(input logic [15:0] v);
        sx16 = {{16{v[15]}}, v};
    endfunction

    // Arithmetic shift right of a 32-bit word
    function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] n);
        asr = 32'($signed(v) >>> n);
    endfunction

    // Signed division by four, truncating toward zero
    function automatic logic [31:0] sdiv4(input logic [31:0] v);
        logic [31:0] b;
        b = v + (v[31] ? 32'd3 : 32'd0);
        sdiv4 = asr(b, 5'd2);
    endfunction

endpackage
`default_nettype wire

[hdl/btpc_div.sv]
// ----------------------------------------------------------------------------
// btpc_div: pipelined unsigned 32 by 32 divider
// One quotient bit per stage, a new division accepted in every cycle; a
// sideband word travels alongside. Advances only when en is high.
// ----------------------------------------------------------------------------
`default_nettype none
module btpc_div
    import btpc_pkg::*;
#(
    parameter int unsigned SideW = 8
) (
    input  wire logic             aclk,
    input  wire logic             en,
    input  wire logic [31:0]      num,
    input  wire logic [31:0]      den,
    input  wire logic [SideW-1:0] side_in,
    output logic      [31:0]      quo,
    output logic      [SideW-1:0] side_out
);

    logic [31:0]      rem_reg  [1:DivStages];
    logic [31:0]      q_reg    [1:DivStages];
    logic [31:0]      d_reg    [1:DivStages];
    logic [SideW-1:0] side_reg [1:DivStages];

    // Restoring division, one bit a stage
    for (genvar i = 0; i < DivStages; i++) begin : g_stage
        logic [31:0]      rem_in, q_in, d_in;
        logic [SideW-1:0] side_w;
        logic [32:0]      trial;
        logic [32:0]      diff;
        // Feed the first stage from the ports, the rest from the stage before
        if (i == 0) begin : g_first
            assign rem_in = 32'd0;
            assign q_in   = num;
            assign d_in   = den;
            assign side_w = side_in;
        end else begin : g_next
            assign rem_in = rem_reg[i];
            assign q_in   = q_reg[i];
            assign d_in   = d_reg[i];
            assign side_w = side_reg[i];
        end
        always_comb begin
            trial = {rem_in, q_in[31]};
            diff  = trial - {1'b0, d_in};
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                if (!diff[32]) begin
                    rem_reg[i+1] <= diff[31:0];
                end else begin
                    rem_reg[i+1] <= trial[31:0];
                end
                q_reg[i+1]    <= {q_in[30:0], ~diff[32]};
                d_reg[i+1]    <= d_in;
                side_reg[i+1] <= side_w;
            end
        end
    end

    assign quo      = q_reg[DivStages];
    assign side_out = side_reg[DivStages];

endmodule
`default_nettype wire

[hdl/barometer_temp_pressure_compensation.sv]
// Throughput: one transaction per cycle unless the result side stalls; two
// pipelined 32-stage dividers (temperature quotient, then b7*2/b4 or b7/b4) set
// most of the depth.
// A stall on the result side freezes the whole pipeline; nothing is lost.
// Reset (aresetn low, synchronous) clears valid bits and coefficients.
// ----------------------------------------------------------------------------
// barometer_temp_pressure_compensation: temperature and pressure compensation
// Pipelined 32-bit integer compensation of raw sensor readings.
// ----------------------------------------------------------------------------
`default_nettype none
module barometer_temp_pressure_compensation
    import btpc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // raw_temp[15:0], raw_press[31:16]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // temp_tenths_c[31:0], press_pa[63:32]
    output logic             m_tuser    // div_error
);

    logic [15:0] ac1_reg, ac2_reg, ac3_reg, ac4_reg, ac5_reg, ac6_reg;
    logic [31:0] b12_reg, mcmd_reg;

    assign cfg_ready = 1'b1;

    // Hold coefficients
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ac1_reg <= '0; ac2_reg <= '0; ac3_reg <= '0;
            ac4_reg <= '0; ac5_reg <= '0; ac6_reg <= '0;
            b12_reg <= '0; mcmd_reg <= '0;
        end else if (cfg_valid) begin
            unique case (reg_idx_t'(cfg_index))
                REG_AC1:   ac1_reg  <= cfg_data[15:0];
                REG_AC2:   ac2_reg  <= cfg_data[15:0];
                REG_AC3:   ac3_reg  <= cfg_data[15:0];
                REG_AC4:   ac4_reg  <= cfg_data[15:0];
                REG_AC5:   ac5_reg  <= cfg_data[15:0];
                REG_AC6:   ac6_reg  <= cfg_data[15:0];
                REG_B1_B2: b12_reg  <= cfg_data;
                REG_MC_MD: mcmd_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    logic [31:0] ac1, ac2, ac3, b1, b2, mc, md;
    assign ac1 = sx16(ac1_reg);
    assign ac2 = sx16(ac2_reg);
    assign ac3 = sx16(ac3_reg);
    assign b1  = sx16(b12_reg[15:0]);
    assign b2  = sx16(b12_reg[31:16]);
    assign mc  = sx16(mcmd_reg[15:0]);
    assign md  = sx16(mcmd_reg[31:16]);

    // Global advance: the output register is free or being emptied
    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // ---- stage 1: ut - ac6, multiply by ac5
    logic        v1_reg;
    logic [31:0] p1_reg;
    logic [15:0] up1_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v1_reg <= 1'b0;
        else if (adv) v1_reg <= s_tvalid;
        if (adv) begin
            p1_reg  <= ({16'd0, s_tdata[15:0]} - {16'd0, ac6_reg}) * {16'd0, ac5_reg};
            up1_reg <= s_tdata[31:16];
        end
    end

    // ---- stage 2: x1, denominator, mc << 11
    logic        v2_reg;
    logic [31:0] x1t2_reg, den2_reg, num2_reg;
    logic [15:0] up2_reg;
    logic [31:0] x1t;
    assign x1t = asr(p1_reg, 5'd15);
    always_ff @(posedge aclk) begin
        if (!aresetn) v2_reg <= 1'b0;
        else if (adv) v2_reg <= v1_reg;
        if (adv) begin
            x1t2_reg <= x1t;
            den2_reg <= x1t + md;
            num2_reg <= mc << 11;
            up2_reg  <= up1_reg;
        end
    end

    // ---- temperature division: signed via magnitudes
    localparam int unsigned TSideW = 1 + 32 + 16 + 1 + 1;
    logic [31:0] tn_mag, td_mag, tq_raw;
    logic [TSideW-1:0] tside_out;
    assign tn_mag = num2_reg[31] ? -num2_reg : num2_reg;
    assign td_mag = den2_reg[31] ? -den2_reg : den2_reg;

    btpc_div #(.SideW(TSideW)) u_tdiv (
        .aclk     (aclk),
        .en       (adv),
        .num      (tn_mag),
        .den      (td_mag),
        .side_in  ({v2_reg, x1t2_reg, up2_reg, num2_reg[31] ^ den2_reg[31],
                    den2_reg == 32'd0}),
        .quo      (tq_raw),
        .side_out (tside_out)
    );

    logic        vt;
    logic [31:0] x1t_d;
    logic [15:0] up_d;
    logic        tneg, terr;
    assign {vt, x1t_d, up_d, tneg, terr} = tside_out;
    logic vt_live;
    // Valid bit inside the divider has no reset; gate with a reset shadow
    logic [DivStages-1:0] tvq_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) tvq_reg <= '0;
        else if (adv) tvq_reg <= {tvq_reg[DivStages-2:0], v2_reg};
    end
    assign vt_live = tvq_reg[DivStages-1] & vt;

    // ---- stage 3: b5, t, b6
    logic        v3_reg, e3_reg;
    logic [31:0] t3_reg, b6_3_reg;
    logic [15:0] up3_reg;
    logic [31:0] x2t, b5;
    assign x2t = tneg ? -tq_raw : tq_raw;
    assign b5  = x1t_d + x2t;
    always_ff @(posedge aclk) begin
        if (!aresetn) v3_reg <= 1'b0;
        else if (adv) v3_reg <= vt_live;
        if (adv) begin
            e3_reg   <= terr;
            t3_reg   <= asr(b5 + 32'd8, 5'd4);
            b6_3_reg <= b5 - B6_OFFSET;
            up3_reg  <= up_d;
        end
    end

    // ---- stage 4: products with b6
    logic        v4_reg, e4_reg;
    logic [31:0] t4_reg, b6_4_reg, sqp4_reg, ac2b6_4_reg, ac3b6_4_reg;
    logic [15:0] up4_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v4_reg <= 1'b0;
        else if (adv) v4_reg <= v3_reg;
        if (adv) begin
            e4_reg      <= e3_reg;
            t4_reg      <= t3_reg;
            b6_4_reg    <= b6_3_reg;
            sqp4_reg    <= b6_3_reg * b6_3_reg;
            ac2b6_4_reg <= ac2 * b6_3_reg;
            ac3b6_4_reg <= ac3 * b6_3_reg;
            up4_reg     <= up3_reg;
        end
    end

    // ---- stage 5: products with sq
    logic        v5_reg, e5_reg;
    logic [31:0] t5_reg, b2sq5_reg, b1sq5_reg, ac2b6_5_reg, ac3b6_5_reg;
    logic [15:0] up5_reg;
    logic [31:0] sq;
    assign sq = asr(sqp4_reg, 5'd12);
    always_ff @(posedge aclk) begin
        if (!aresetn) v5_reg <= 1'b0;
        else if (adv) v5_reg <= v4_reg;
        if (adv) begin
            e5_reg      <= e4_reg;
            t5_reg      <= t4_reg;
            b2sq5_reg   <= b2 * sq;
            b1sq5_reg   <= b1 * sq;
            ac2b6_5_reg <= ac2b6_4_reg;
            ac3b6_5_reg <= ac3b6_4_reg;
            up5_reg     <= up4_reg;
        end
    end

    // ---- stage 6: b3 and x3
    logic        v6_reg, e6_reg;
    logic [31:0] t6_reg, b3_6_reg, x3_6_reg;
    logic [15:0] up6_reg;
    logic [31:0] x3a, x3b;
    assign x3a = asr(b2sq5_reg, 5'd11) + asr(ac2b6_5_reg, 5'd11);
    assign x3b = asr(ac3b6_5_reg, 5'd13) + asr(b1sq5_reg, 5'd16);
    always_ff @(posedge aclk) begin
        if (!aresetn) v6_reg <= 1'b0;
        else if (adv) v6_reg <= v5_reg;
        if (adv) begin
            e6_reg   <= e5_reg;
            t6_reg   <= t5_reg;
            b3_6_reg <= sdiv4((ac1 << 2) + x3a + 32'd2);
            x3_6_reg <= sdiv4(x3b + 32'd2);
            up6_reg  <= up5_reg;
        end
    end

    // ---- stage 7: ac4 product and up - b3
    logic        v7_reg, e7_reg;
    logic [31:0] t7_reg, b4p7_reg, upb3_7_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v7_reg <= 1'b0;
        else if (adv) v7_reg <= v6_reg;
        if (adv) begin
            e7_reg     <= e6_reg;
            t7_reg     <= t6_reg;
            b4p7_reg   <= {16'd0, ac4_reg} * (x3_6_reg + X3_BIAS);
            upb3_7_reg <= {16'd0, up6_reg} - b3_6_reg;
        end
    end

    // ---- stage 8: b4 and b7
    logic        v8_reg, e8_reg;
    logic [31:0] t8_reg, b4_8_reg, b7_8_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v8_reg <= 1'b0;
        else if (adv) v8_reg <= v7_reg;
        if (adv) begin
            e8_reg   <= e7_reg;
            t8_reg   <= t7_reg;
            b4_8_reg <= b4p7_reg >> 15;
            b7_8_reg <= upb3_7_reg * B7_SCALE;
        end
    end

    // ---- pressure division: one divider for either form
    localparam int unsigned PSideW = 1 + 1 + 32 + 1;
    logic [31:0] pnum, pq;
    logic [PSideW-1:0] pside_out;
    assign pnum = b7_8_reg[31] ? b7_8_reg : (b7_8_reg << 1);

    btpc_div #(.SideW(PSideW)) u_pdiv (
        .aclk     (aclk),
        .en       (adv),
        .num      (pnum),
        .den      (b4_8_reg),
        .side_in  ({b7_8_reg[31], e8_reg | (b4_8_reg == 32'd0), t8_reg, 1'b0}),
        .quo      (pq),
        .side_out (pside_out)
    );

    logic        pdbl, perr, pspare;
    logic [31:0] t_d;
    assign {pdbl, perr, t_d, pspare} = pside_out;

    logic [DivStages-1:0] pvq_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) pvq_reg <= '0;
        else if (adv) pvq_reg <= {pvq_reg[DivStages-2:0], v8_reg};
    end

    // ---- stage 9: p and correction products
    logic        v9_reg, e9_reg;
    logic [31:0] t9_reg, p9_reg, sqp9_reg, lin9_reg;
    logic [31:0] p_q, p8;
    assign p_q = pdbl ? (pq << 1) : pq;
    assign p8  = asr(p_q, 5'd8);
    always_ff @(posedge aclk) begin
        if (!aresetn) v9_reg <= 1'b0;
        else if (adv) v9_reg <= pvq_reg[DivStages-1];
        if (adv) begin
            e9_reg   <= perr | pspare;
            t9_reg   <= t_d;
            p9_reg   <= p_q;
            sqp9_reg <= p8 * p8;
            lin9_reg <= 32'd0 - P_LIN_K * p_q;
        end
    end

    // ---- stage 10: scale square and linear terms
    logic        v10_reg, e10_reg;
    logic [31:0] t10_reg, p10_reg, x1_10_reg, x2_10_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v10_reg <= 1'b0;
        else if (adv) v10_reg <= v9_reg;
        if (adv) begin
            e10_reg   <= e9_reg;
            t10_reg   <= t9_reg;
            p10_reg   <= p9_reg;
            x1_10_reg <= sqp9_reg * P_SQ_K;
            x2_10_reg <= asr(lin9_reg, 5'd16);
        end
    end

    // ---- output register
    logic [31:0] pfin;
    assign pfin = p10_reg + asr(asr(x1_10_reg, 5'd16) + x2_10_reg + P_OFS_K, 5'd4);
    always_ff @(posedge aclk) begin
        if (!aresetn) m_tvalid <= 1'b0;
        else if (adv) m_tvalid <= v10_reg;
        if (adv) begin
            m_tuser <= e10_reg;
            m_tdata <= e10_reg ? 64'd0 : {pfin, t10_reg};
        end
    end

endmodule
`default_nettype wire

[hdl/btpc_checker.sv]
// ----------------------------------------------------------------------------
// btpc_checker: port-level checks of the compensation block
// Watches the stream ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module btpc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata,
    input wire logic        m_tuser
);

    // Hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Error results carry zero data
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == 64'd0)
        else $error("error result with data");

    // Input is taken whenever output is free
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // No result shortly after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result after reset");

endmodule

bind barometer_temp_pressure_compensation btpc_checker u_btpc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
